// ===== src/ial_pkg.sv =====
// Shared types and constants for the indexed array list.
// No dependencies; imported by ial_cell and indexed_array_list.
package ial_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 6;
	localparam int OP_W         = 2;

	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Command broadcast to every slot cell.
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pos_idx;  // 0-based slot addressed
	} cell_cmd_t;

endpackage

// ===== src/ial_cell.sv =====
// One slot of the list: holds an element and shifts with its neighbors.
// Depends on ial_pkg.
module ial_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  ial_pkg::cell_cmd_t          cmd,
	input  logic [ial_pkg::DATA_W-1:0]  value,
	input  logic [ial_pkg::DATA_W-1:0]  left_data,
	input  logic [ial_pkg::DATA_W-1:0]  right_data,
	output logic [ial_pkg::DATA_W-1:0]  data,
	output logic [ial_pkg::DATA_W-1:0]  rd_data
);
	import ial_pkg::*;

	localparam logic [POS_W-1:0] IDX_V = POS_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic              sel;
	logic              above;

	assign sel   = (cmd.pos_idx == IDX_V);
	assign above = (IDX_V > cmd.pos_idx);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (sel)
				data_q <= value;
			else if (above)
				data_q <= left_data;
		end else if (cmd.del) begin
			if (sel || above)
				data_q <= right_data;
		end
	end

	assign data    = data_q;
	assign rd_data = sel ? data_q : '0;

endmodule

// ===== src/indexed_array_list.sv =====
// Top level of the indexed array list: command decode, length, output register.
// Depends on ial_pkg and ial_cell.
//
// Ordered list of up to CAPACITY signed 32-bit elements addressed by 1-based
// position: get, insert-before and delete-at. On insert or delete the row
// of slot cells shifts up or down in parallel on the clock edge that accepts
// the transaction, and the result (status, element, new count) is registered
// and shown the next cycle. A new transaction is taken every cycle as long as
// the result register is empty or being drained. Errors leave the list as is.
module indexed_array_list #(
	parameter int CAPACITY = ial_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // operation[1:0], position[7:2], value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status[0], element[32:1], count[38:33], zero[39]
);
	import ial_pkg::*;

	logic [OP_W-1:0]   op;
	logic [POS_W-1:0]  pos;
	logic [DATA_W-1:0] value;
	logic              s_fire;
	logic              pos_nz;
	logic              get_ok;
	logic              ins_ok;
	logic              del_ok;
	logic              ok;
	logic [POS_W-1:0]  len_q;
	logic [POS_W-1:0]  len_nxt;
	logic [POS_W:0]    len_p1;
	logic              m_tvalid_q;
	logic [39:0]       out_q;
	logic [DATA_W-1:0] element;
	cell_cmd_t         cmd;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_rd   [CAPACITY];

	assign op    = s_tdata[1:0];
	assign pos   = s_tdata[7:2];
	assign value = s_tdata[39:8];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	assign pos_nz = (pos != '0);
	assign len_p1 = {1'b0, len_q} + 7'd1;
	assign get_ok = (op == OP_GET) && pos_nz && (pos <= len_q);
	assign ins_ok = (op == OP_INSERT) && (len_q < POS_W'(CAPACITY)) && pos_nz
		&& ({1'b0, pos} <= len_p1);
	assign del_ok = (op == OP_DELETE) && pos_nz && (pos <= len_q);
	assign ok     = get_ok || ins_ok || del_ok;

	assign cmd.ins     = s_fire && ins_ok;
	assign cmd.del     = s_fire && del_ok;
	assign cmd.pos_idx = pos - POS_W'(1);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [DATA_W-1:0] left_d;
			logic [DATA_W-1:0] right_d;
			if (gi == 0) begin : g_first
				assign left_d = '0;
			end else begin : g_mid_l
				assign left_d = cell_data[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_d = '0;
			end else begin : g_mid_r
				assign right_d = cell_data[gi+1];
			end
			ial_cell #(
				.IDX(gi)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.value      (value),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[gi]),
				.rd_data    (cell_rd[gi])
			);
		end
	endgenerate

	always_comb begin
		element = '0;
		for (int i = 0; i < CAPACITY; i++)
			element = element | cell_rd[i];
		if (!(get_ok || del_ok))
			element = '0;
	end

	always_comb begin
		len_nxt = len_q;
		if (ins_ok)
			len_nxt = len_q + POS_W'(1);
		else if (del_ok)
			len_nxt = len_q - POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				len_q      <= len_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			out_q <= {1'b0, len_nxt, element, !ok};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= POS_W'(CAPACITY))
		else $error("list length exceeds capacity");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && ins_ok |=> len_q == $past(len_q) + POS_W'(1))
		else $error("insert did not grow the list");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !ok |=> $stable(len_q))
		else $error("failed transaction changed the length");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> m_tvalid && m_tdata[38:33] == len_q)
		else $error("result missing or count mismatch");

endmodule
